/* design/crxf_pkg.sv */
// Shared constants, types and helper functions for the CAN receive ID/mask filter.
// Used by crxf_ram's users, crxf_engine and can_rx_id_mask_filter_core; no dependencies.
`timescale 1ns / 1ps
package crxf_pkg;

  // Table size and derived widths.
  localparam int TABLE_ENTRIES = 64;
  localparam int ENTRY_AW      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);

  // Field widths fixed by the interface.
  localparam int ID_W          = 11;
  localparam int KEY_W         = ID_W + 1;
  localparam int ENTRY_INDEX_W = 16;
  localparam int FMI_W         = 8;
  localparam int DIDX_W        = 6;
  localparam int EIU_W         = 7;
  localparam int RAM_W         = 2 * KEY_W;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam logic [CFG_INDEX_W-1:0] REG_ENTRIES_IN_USE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FILTER_INDEX_MODE = 2'd1;
  localparam logic [EIU_W-1:0]       EIU_RESET             = 7'd64;

  // Item kinds carried on tuser.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FRAME = 1'b1;

  // Write status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ILLEGAL = 1'b1;

  // Contents that an entry never written reads as.
  localparam logic [KEY_W-1:0] KEY_RESET  = '0;
  localparam logic [KEY_W-1:0] MASK_RESET = '1;

  typedef struct packed {
    logic                     action;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [ID_W-1:0]          entry_ident;
    logic [ID_W-1:0]          entry_mask;
    logic                     entry_rtr;
    logic                     entry_enable;
    logic [ID_W-1:0]          frame_ident;
    logic                     frame_rtr;
    logic [FMI_W-1:0]         filter_match_index;
  } crxf_item_t;

  typedef struct packed {
    logic              status;
    logic              matched;
    logic              deliver;
    logic [DIDX_W-1:0] deliver_index;
  } crxf_result_t;

  // Entries in use, clipped to the table size.
  function automatic logic [COUNT_W-1:0] used_count(input logic [EIU_W-1:0] eiu);
    logic [EIU_W+COUNT_W-1:0] wide;
    logic [COUNT_W-1:0]       res;
    wide = {{COUNT_W{1'b0}}, eiu};
    if (wide > (EIU_W + COUNT_W)'(TABLE_ENTRIES)) begin
      res = COUNT_W'(TABLE_ENTRIES);
    end else begin
      res = wide[COUNT_W-1:0];
    end
    return res;
  endfunction

  // Low bits of an entry address as reported on deliver_index.
  function automatic logic [DIDX_W-1:0] to_didx(input logic [ENTRY_AW-1:0] addr);
    logic [DIDX_W+ENTRY_AW-1:0] wide;
    wide = {{DIDX_W{1'b0}}, addr};
    return wide[DIDX_W-1:0];
  endfunction

endpackage

/* design/can_rx_id_mask_filter_core.sv */
// Top level of the CAN receive ID/mask acceptance filter: stream ports, config registers,
// output register and checks. Depends on crxf_pkg and crxf_engine.
// A table write, a filter-index lookup or a search with no entries in use passes through
// the engine's result register and then the output register. A search reads one entry per
// cycle through the one read port of the key/mask RAM and stops at the first hit, or after
// the last entry in use with no hit. The block takes one item at a time: it takes no new
// input until the result of the last one has been handed to the output register. Reset
// (rst, synchronous, active high) restores 64 entries in use and search mode and clears
// all entry valid bits at once; no sweep.
`timescale 1ns / 1ps
module can_rx_id_mask_filter_core (
  input  logic                              clk,
  input  logic                              rst,
  // Input beats. tdata, from bit 0 up: entry_index[15:0], entry_ident[26:16],
  // entry_mask[37:27], entry_rtr[38], entry_enable[39], frame_ident[50:40],
  // frame_rtr[51], filter_match_index[59:52], zero fill[63:60].
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [63:0]                       s_tdata,
  // tuser: action (0 table write, 1 received frame).
  input  logic                              s_tuser,
  // Result beats. tdata, from bit 0 up: status[0], matched[1], deliver[2],
  // deliver_index[8:3], zero fill[15:9].
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [crxf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [crxf_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [crxf_pkg::EIU_W-1:0] entries_in_use;
  logic                       filter_index_mode;
  crxf_pkg::crxf_item_t       item;
  crxf_pkg::crxf_result_t     res, out_res;
  logic                       res_valid, res_ready;
  logic [crxf_pkg::COUNT_W-1:0] n_used;

  // Registers are always writable; software must change them only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use    <= crxf_pkg::EIU_RESET;
      filter_index_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crxf_pkg::REG_ENTRIES_IN_USE:    entries_in_use    <= cfg_data;
        crxf_pkg::REG_FILTER_INDEX_MODE: filter_index_mode <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A count above the table size behaves as the table size.
  assign n_used = crxf_pkg::used_count(entries_in_use);

  // Unpack the input beat into the item fields.
  assign item.action             = s_tuser;
  assign item.entry_index        = s_tdata[15:0];
  assign item.entry_ident        = s_tdata[26:16];
  assign item.entry_mask         = s_tdata[37:27];
  assign item.entry_rtr          = s_tdata[38];
  assign item.entry_enable       = s_tdata[39];
  assign item.frame_ident        = s_tdata[50:40];
  assign item.frame_rtr          = s_tdata[51];
  assign item.filter_match_index = s_tdata[59:52];

  crxf_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s_tvalid),
    .item_ready  (s_tready),
    .item        (item),
    .n_used      (n_used),
    .filter_mode (filter_index_mode),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // Output register: the engine hands over its result whenever the register is free or
  // being emptied in the same cycle, so it can start on the next beat right away.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.deliver_index, out_res.deliver, out_res.matched,
                    out_res.status};

  // The engine works on one beat at a time: right after taking one it is busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while the previous beat was still in work");

  // Delivery only ever goes to a matched entry.
  a_deliver_needs_match: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.deliver) |-> res.matched)
    else $error("deliver set without a match");

  // Without a match the reported index is zero.
  a_index_zero_no_match: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.matched) |-> (res.deliver_index == '0))
    else $error("nonzero deliver_index without a match");

  // A result is handed over only while the engine is not taking input.
  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !s_tready)
    else $error("engine ready while holding a result");

endmodule

/* design/crxf_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies; used by crxf_engine for the key/mask table.
`timescale 1ns / 1ps
module crxf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/crxf_engine.sv */
// Table engine: programs entries, walks the key/mask RAM for a search, and holds the result.
// Also serves filter-index lookups. Depends on crxf_pkg and crxf_ram.
`timescale 1ns / 1ps
module crxf_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  crxf_pkg::crxf_item_t           item,
  input  logic [crxf_pkg::COUNT_W-1:0]   n_used,
  input  logic                           filter_mode,
  output logic                           res_valid,
  input  logic                           res_ready,
  output crxf_pkg::crxf_result_t         res
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DONE   = 3'b100
  } state_t;

  state_t                            state, state_next;
  logic [crxf_pkg::COUNT_W-1:0]      rd_cnt, rd_cnt_next;
  logic [crxf_pkg::COUNT_W-1:0]      cmp_cnt, cmp_cnt_next;
  logic                              cmp_pend, cmp_pend_next;
  logic [crxf_pkg::KEY_W-1:0]        key, key_next;
  crxf_pkg::crxf_result_t            res_next;
  logic [crxf_pkg::TABLE_ENTRIES-1:0] entry_valid;

  logic                              ram_we, ram_re, valid_set;
  logic [crxf_pkg::ENTRY_AW-1:0]     waddr, raddr, cmp_addr, fmi_addr;
  logic [crxf_pkg::RAM_W-1:0]        wdata, rdata;
  logic [crxf_pkg::KEY_W-1:0]        skey, smask;

  crxf_ram #(
    .DEPTH (crxf_pkg::TABLE_ENTRIES),
    .WIDTH (crxf_pkg::RAM_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign waddr    = item.entry_index[crxf_pkg::ENTRY_AW-1:0];
  assign wdata    = {1'b1, item.entry_mask, item.entry_rtr, item.entry_ident};
  assign raddr    = rd_cnt[crxf_pkg::ENTRY_AW-1:0];
  assign cmp_addr = cmp_cnt[crxf_pkg::ENTRY_AW-1:0];
  assign fmi_addr = item.filter_match_index[crxf_pkg::ENTRY_AW-1:0];

  // An entry never written compares with its reset contents, whatever the RAM holds.
  always_comb begin
    if (entry_valid[cmp_addr]) begin
      skey  = rdata[crxf_pkg::KEY_W-1:0];
      smask = rdata[crxf_pkg::RAM_W-1:crxf_pkg::KEY_W];
    end else begin
      skey  = crxf_pkg::KEY_RESET;
      smask = crxf_pkg::MASK_RESET;
    end
  end

  assign item_ready = (state == ST_IDLE);
  assign res_valid  = (state == ST_DONE);

  always_comb begin
    state_next    = state;
    rd_cnt_next   = rd_cnt;
    cmp_cnt_next  = rd_cnt;
    cmp_pend_next = 1'b0;
    key_next      = key;
    res_next      = res;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    valid_set     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          res_next   = '0;
          state_next = ST_DONE;
          if (item.action == crxf_pkg::ACT_WRITE) begin
            if (item.entry_enable && (32'(item.entry_index) < 32'(n_used))) begin
              ram_we          = 1'b1;
              valid_set       = 1'b1;
              res_next.status = crxf_pkg::STATUS_OK;
            end else begin
              res_next.status = crxf_pkg::STATUS_ILLEGAL;
            end
          end else if (filter_mode) begin
            if (32'(item.filter_match_index) < 32'(n_used)) begin
              res_next.matched       = 1'b1;
              res_next.deliver       = entry_valid[fmi_addr];
              res_next.deliver_index = crxf_pkg::to_didx(fmi_addr);
            end
          end else if (n_used != '0) begin
            key_next    = {item.frame_rtr, item.frame_ident};
            rd_cnt_next = '0;
            state_next  = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (rd_cnt < n_used) begin
          ram_re        = 1'b1;
          rd_cnt_next   = rd_cnt + crxf_pkg::COUNT_W'(1);
          cmp_pend_next = 1'b1;
        end
        if (cmp_pend) begin
          if (((key ^ skey) & smask) == '0) begin
            res_next.matched       = 1'b1;
            res_next.deliver       = entry_valid[cmp_addr];
            res_next.deliver_index = crxf_pkg::to_didx(cmp_addr);
            state_next             = ST_DONE;
          end else if (cmp_cnt == n_used - crxf_pkg::COUNT_W'(1)) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cmp_pend    <= 1'b0;
      entry_valid <= '0;
    end else begin
      state    <= state_next;
      cmp_pend <= cmp_pend_next;
      if (valid_set) begin
        entry_valid[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt  <= rd_cnt_next;
    cmp_cnt <= cmp_cnt_next;
    key     <= key_next;
    res     <= res_next;
  end

endmodule
